[sv/dcrt_pkg.sv]
`default_nettype none
package dcrt_pkg;

  localparam int unsigned NumChannels = 4;
  localparam int unsigned MaxChannels = 4;
  localparam int unsigned SlotW       = 2;
  localparam int unsigned ElapsedW    = 30;
  localparam int unsigned DutyRegW    = 31;
  localparam int unsigned DutyW       = 7;
  localparam int unsigned PeriodW     = 16;
  localparam int unsigned ThrW        = 23;
  localparam int unsigned ThrMsW      = 27;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 31;

  localparam logic [DutyW-1:0] DutyFull = 7'd100;

  typedef enum logic [1:0] {
    FuncTick  = 2'd0,
    FuncSet   = 2'd1,
    FuncQuery = 2'd2
  } dcrt_func_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgDuty    = 3'd0,
    CfgPeriod0 = 3'd1,
    CfgPeriod1 = 3'd2,
    CfgPeriod2 = 3'd3,
    CfgPeriod3 = 3'd4,
    CfgOnLevel = 3'd5
  } dcrt_cfg_e;

  typedef struct packed {
    logic [1:0] func;
    logic [1:0] channel;
    logic       switch_on;
  } dcrt_in_t;

  typedef struct packed {
    logic [MaxChannels-1:0] relay_levels;
    logic [MaxChannels-1:0] changed_mask;
    logic                   query_on;
  } dcrt_out_t;

  // one pipeline slot: a tick expands to one slot per channel
  typedef struct packed {
    logic             valid;
    logic [1:0]       func;
    logic [1:0]       channel;
    logic             switch_on;
    logic [SlotW-1:0] slot;
    logic             first;
    logic             last;
  } dcrt_slot_t;

  function automatic logic [DutyW-1:0] duty_clamp(input logic [7:0] b);
    logic [DutyW-1:0] r;
    if (b > 8'(DutyFull)) begin
      r = DutyFull;
    end else begin
      r = b[DutyW-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[sv/dcrt_seq.sv]
`default_nettype none
module dcrt_seq #(
  parameter int unsigned CHANNELS = dcrt_pkg::NumChannels
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 adv_i,
  input  wire logic                 in_valid_i,
  input  wire dcrt_pkg::dcrt_in_t   in_data_i,
  output logic                      in_stall_o,
  output dcrt_pkg::dcrt_slot_t      s1_o
);
  import dcrt_pkg::*;

  localparam logic [SlotW-1:0] LastSlot = SlotW'(CHANNELS - 1);

  dcrt_slot_t s1_q, s1_d;
  logic       done;
  logic       take;
  logic       accept;

  assign done       = (s1_q.func != FuncTick) || (s1_q.slot == LastSlot);
  assign take       = adv_i && (!s1_q.valid || done);
  assign in_stall_o = !take;
  assign accept     = in_valid_i && take;

  always_comb begin
    s1_d = s1_q;
    if (adv_i) begin
      if (s1_q.valid && !done) begin
        s1_d.slot  = s1_q.slot + SlotW'(1);
        s1_d.first = 1'b0;
        s1_d.last  = (s1_q.slot + SlotW'(1)) == LastSlot;
      end else if (accept) begin
        s1_d.valid     = 1'b1;
        s1_d.func      = in_data_i.func;
        s1_d.channel   = in_data_i.channel;
        s1_d.switch_on = in_data_i.switch_on;
        s1_d.slot      = '0;
        s1_d.first     = 1'b1;
        s1_d.last      = (in_data_i.func != FuncTick) || (LastSlot == '0);
      end else begin
        s1_d.valid = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else begin
      s1_q <= s1_d;
    end
  end

  assign s1_o = s1_q;

endmodule
`default_nettype wire

[sv/dcrt_elapsed_mem.sv]
`default_nettype none
module dcrt_elapsed_mem #(
  parameter int unsigned CHANNELS = dcrt_pkg::NumChannels
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            rd_en_i,
  input  wire logic [dcrt_pkg::SlotW-1:0]      rd_addr_i,
  input  wire logic                            we_i,
  input  wire logic [dcrt_pkg::SlotW-1:0]      wr_addr_i,
  input  wire logic [dcrt_pkg::ElapsedW-1:0]   wr_data_i,
  output logic      [dcrt_pkg::ElapsedW-1:0]   rd_data_o
);
  import dcrt_pkg::*;

  localparam int unsigned AddrW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [ElapsedW-1:0] mem_q [CHANNELS];
  logic [CHANNELS-1:0] written_q;
  logic [ElapsedW-1:0] rd_q;
  logic                rd_vld_q;
  logic                fwd_q;
  logic [ElapsedW-1:0] fwd_data_q;
  logic [AddrW-1:0]    raddr;
  logic [AddrW-1:0]    waddr;

  assign raddr = rd_addr_i[AddrW-1:0];
  assign waddr = wr_addr_i[AddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q       <= mem_q[raddr];
      fwd_data_q <= wr_data_i;
    end
  end

  // unwritten entries read as saturated; same-entry write wins over the read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      rd_vld_q  <= 1'b0;
      fwd_q     <= 1'b0;
    end else begin
      if (we_i) begin
        written_q[waddr] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= written_q[raddr];
        fwd_q    <= we_i && (waddr == raddr);
      end
    end
  end

  assign rd_data_o = fwd_q    ? fwd_data_q :
                     rd_vld_q ? rd_q       : '1;

endmodule
`default_nettype wire

[sv/dcrt_eval.sv]
`default_nettype none
module dcrt_eval #(
  parameter int unsigned CHANNELS = dcrt_pkg::NumChannels
) (
  input  wire logic                                                   clk_i,
  input  wire logic                                                   rst_ni,
  input  wire logic                                                   adv_i,
  input  wire dcrt_pkg::dcrt_slot_t                                   s1_i,
  input  wire logic [dcrt_pkg::DutyRegW-1:0]                          duty_percents_i,
  input  wire logic [dcrt_pkg::MaxChannels-1:0][dcrt_pkg::PeriodW-1:0] period_i,
  input  wire logic                                                   on_level_i,
  input  wire logic [dcrt_pkg::ElapsedW-1:0]                          elapsed_i,
  output logic                                                        mem_we_o,
  output logic      [dcrt_pkg::SlotW-1:0]                             mem_addr_o,
  output logic      [dcrt_pkg::ElapsedW-1:0]                          mem_wdata_o,
  output logic                                                        res_valid_o,
  output dcrt_pkg::dcrt_out_t                                         res_o
);
  import dcrt_pkg::*;

  // stage 1: thresholds in seconds*percent
  logic [31:0]       duty_word;
  logic [DutyW-1:0]  duty;
  logic [PeriodW-1:0] period;
  logic [ThrW-1:0]   prod_on;
  logic [ThrW-1:0]   prod_off;

  assign duty_word = {1'b0, duty_percents_i};
  assign duty      = duty_clamp(duty_word[8 * s1_i.slot +: 8]);
  assign period    = period_i[s1_i.slot];
  assign prod_on   = ThrW'(duty) * ThrW'(period);
  assign prod_off  = ThrW'(DutyFull - duty) * ThrW'(period);

  dcrt_slot_t       s2_q;
  logic [ThrW-1:0]  thr_on_q;
  logic [ThrW-1:0]  thr_off_q;
  logic             duty_nz_q;
  logic             duty_full_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      thr_on_q    <= prod_on;
      thr_off_q   <= prod_off;
      duty_nz_q   <= duty != '0;
      duty_full_q <= duty == DutyFull;
    end
  end

  logic [MaxChannels-1:0] levels_q, levels_d;
  logic [MaxChannels-1:0] acc_q, acc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q     <= '0;
      levels_q <= '0;
      acc_q    <= '0;
    end else if (adv_i) begin
      s2_q     <= s1_i;
      levels_q <= levels_d;
      acc_q    <= acc_d;
    end
  end

  // stage 2: compare, toggle, write back
  logic                 lvl;
  logic                 is_on;
  logic [ThrW-1:0]      thr_sel;
  logic [ThrMsW-1:0]    thr_ms;
  logic [ElapsedW-1:0]  e_inc;
  logic                 hit;
  logic                 fire;
  logic                 ch_ok;
  logic [MaxChannels-1:0] chg;
  logic                 query;

  assign lvl     = levels_q[s2_q.slot];
  assign is_on   = lvl == on_level_i;
  assign thr_sel = is_on ? thr_on_q : thr_off_q;
  assign thr_ms  = ThrMsW'({thr_sel, 3'b000}) + ThrMsW'({thr_sel, 1'b0});
  assign e_inc   = (elapsed_i == '1) ? elapsed_i : elapsed_i + ElapsedW'(1);
  assign hit     = duty_nz_q && !(is_on && duty_full_q) && (e_inc >= ElapsedW'(thr_ms));
  assign fire    = s2_q.valid && adv_i;
  assign ch_ok   = {1'b0, s2_q.channel} < 3'(CHANNELS);

  always_comb begin
    levels_d = levels_q;
    acc_d    = acc_q;
    chg      = '0;
    query    = 1'b0;
    unique case (s2_q.func)
      FuncTick: begin
        chg = s2_q.first ? '0 : acc_q;
        if (hit) begin
          chg[s2_q.slot]      = 1'b1;
          levels_d[s2_q.slot] = ~lvl;
        end
        acc_d = chg;
      end
      FuncSet: begin
        if (ch_ok) begin
          levels_d[s2_q.channel] = s2_q.switch_on ? on_level_i : ~on_level_i;
          chg[s2_q.channel]      = 1'b1;
        end
      end
      FuncQuery: begin
        query = ch_ok && (levels_q[s2_q.channel] == on_level_i);
      end
      default: begin
      end
    endcase
    if (!fire) begin
      levels_d = levels_q;
      acc_d    = acc_q;
    end
  end

  assign mem_we_o    = fire && (s2_q.func == FuncTick);
  assign mem_addr_o  = s2_q.slot;
  assign mem_wdata_o = hit ? '0 : e_inc;

  assign res_valid_o        = s2_q.valid && s2_q.last;
  assign res_o.relay_levels = levels_d;
  assign res_o.changed_mask = chg;
  assign res_o.query_on     = query;

endmodule
`default_nettype wire

[sv/four_channel_duty_cycle_relay_timer_core.sv]
// Four-channel duty-cycle relay timer.
// Input channel (in_valid_i / in_stall_o / in_data_i) takes one beat per item:
// a one-millisecond tick, a set of one channel, or a query of one channel.
// Output channel (out_valid_o / out_stall_i / out_data_o) gives exactly one
// beat per item, in order: relay levels after the item, changed mask, query bit.
// Config port: cfg_we_i with cfg_idx_i (0 duty bytes, 1..4 periods, 5 on level)
// and cfg_wdata_i; write only while the block is idle.
// Elapsed counts live in a synchronous RAM, one entry per channel.
// A tick is read-modify-written one channel per cycle while the pipeline is
// not frozen; set and query items take one slot each. An item passes the
// sequencer slot register, the evaluate stage register and the output register.
// Reset clears relay levels, sets all elapsed counts saturated (per-entry
// written bits), clears the duty bytes and periods and sets on level to 1.
// When the receiver stalls, the output register holds its beat; the next
// finished result waits in the last stage, and in_stall_o stays high until
// the receiver takes the held beat.
`default_nettype none
module four_channel_duty_cycle_relay_timer_core #(
  parameter int unsigned CHANNELS = dcrt_pkg::NumChannels
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire dcrt_pkg::dcrt_in_t              in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output dcrt_pkg::dcrt_out_t                  out_data_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [dcrt_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [dcrt_pkg::CfgDataW-1:0]   cfg_wdata_i
);
  import dcrt_pkg::*;

  logic [DutyRegW-1:0]                 duty_q;
  logic [MaxChannels-1:0][PeriodW-1:0] period_q;
  logic                                on_level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q     <= '0;
      period_q   <= '0;
      on_level_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgDuty:    duty_q      <= cfg_wdata_i[DutyRegW-1:0];
        CfgPeriod0: period_q[0] <= cfg_wdata_i[PeriodW-1:0];
        CfgPeriod1: period_q[1] <= cfg_wdata_i[PeriodW-1:0];
        CfgPeriod2: period_q[2] <= cfg_wdata_i[PeriodW-1:0];
        CfgPeriod3: period_q[3] <= cfg_wdata_i[PeriodW-1:0];
        CfgOnLevel: on_level_q  <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  logic                adv;
  dcrt_slot_t          s1;
  logic                mem_we;
  logic [SlotW-1:0]    mem_addr;
  logic [ElapsedW-1:0] mem_wdata;
  logic [ElapsedW-1:0] elapsed;
  logic                res_valid;
  dcrt_out_t           res;
  logic                out_valid_q;
  dcrt_out_t           out_q;

  // the pipeline freezes only when a finished result cannot enter the output register
  assign adv = !res_valid || !out_valid_q || !out_stall_i;

  dcrt_seq #(.CHANNELS(CHANNELS)) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .s1_o       (s1)
  );

  dcrt_elapsed_mem #(.CHANNELS(CHANNELS)) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (adv),
    .rd_addr_i (s1.slot),
    .we_i      (mem_we),
    .wr_addr_i (mem_addr),
    .wr_data_i (mem_wdata),
    .rd_data_o (elapsed)
  );

  dcrt_eval #(.CHANNELS(CHANNELS)) u_eval (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .adv_i           (adv),
    .s1_i            (s1),
    .duty_percents_i (duty_q),
    .period_i        (period_q),
    .on_level_i      (on_level_q),
    .elapsed_i       (elapsed),
    .mem_we_o        (mem_we),
    .mem_addr_o      (mem_addr),
    .mem_wdata_o     (mem_wdata),
    .res_valid_o     (res_valid),
    .res_o           (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && adv) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire
